/* design/rmd_pkg.sv */
package rmd_pkg;

  localparam int BISECT_STEPS = 8;
  localparam int WIN_TAPS     = 9;
  localparam int MEDIAN_RANK  = 3 * 3 / 2;
  localparam int CHAN_W       = 8;
  localparam int DIM_W        = 12;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CHAN_W-1:0] CHAN_MIN = 8'h00;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pix_t;

  typedef struct packed {
    logic eol;
    logic eof;
  } tag_t;

endpackage

/* design/rmd_in_if.sv */
interface rmd_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, output req_type, output in_red, output in_green,
                  output in_blue, input ready);
  modport sink (input valid, input req_type, input in_red, input in_green,
                input in_blue, output ready);
endinterface

/* design/rmd_out_if.sv */
interface rmd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       end_of_line;
  logic       end_of_frame;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output end_of_line, output end_of_frame, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input end_of_line, input end_of_frame, output ready);
endinterface

/* design/rmd_ram.sv */
module rmd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/rmd_front.sv */
module rmd_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rmd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [rmd_pkg::DIM_W-1:0]       cfg_wdata,
  rmd_in_if.sink                          in_ch,
  input  logic                            emit_ready,
  output logic                            emit_valid,
  output rmd_pkg::tag_t                   emit_tag,
  output rmd_pkg::pix_t [rmd_pkg::WIN_TAPS-1:0] taps
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int OW = $clog2(MAX_WIDTH + 2);
  localparam int HW = rmd_pkg::DIM_W;

  logic [HW-1:0] width_r, height_r;
  logic [31:0]   w_full;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  logic [AW-1:0] col_r, col_nxt;
  logic [HW-1:0] row_r, row_nxt;
  logic [OW-1:0] ocnt_r, ocnt_nxt;
  logic [WW-1:0] col_inc;
  logic [HW:0]   row_inc;
  logic [HW-1:0] ro;
  logic          primed;
  logic          accept;
  rmd_pkg::pix_t pix_in;

  logic          s1_v_r;
  rmd_pkg::pix_t s1_pix_r;
  logic [AW-1:0] s1_col_r;
  logic [HW-1:0] s1_ro_r;
  logic          s1_primed_r;
  logic          s1_eolmid_r;
  logic          s1_col0_r;
  logic          s1_fwd_r;
  logic [47:0]   s1_fwd_data_r;
  logic          s1_go;

  logic [47:0]   ram_rdata;
  logic [47:0]   line;
  rmd_pkg::pix_t two_up, one_up, top, bot;
  logic          ro_last;

  rmd_pkg::pix_t win_r [3][3];
  logic [HW-1:0] win_row_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rmd_pkg::WIDTH_RESET;
      height_r <= rmd_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        rmd_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        rmd_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_full = 32'd1;
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_full = 32'(MAX_WIDTH);
    end else begin
      w_full = 32'(width_r);
    end
  end

  assign w_eff = w_full[WW-1:0];
  assign h_eff = (height_r == '0) ? HW'(1) : height_r;

  // position counters, advanced on every transaction
  assign accept  = in_ch.valid && in_ch.ready;
  assign col_inc = WW'(col_r) + WW'(1);
  assign row_inc = {1'b0, row_r} + (HW + 1)'(1);
  assign ro      = (row_r == '0) ? (h_eff - HW'(1)) : (row_r - HW'(1));
  assign primed  = ocnt_r >= (OW'(w_eff) + OW'(1));

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    ocnt_nxt = ocnt_r;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[HW-1:0];
    end else begin
      col_nxt = col_inc[AW-1:0];
    end
    if (!primed) begin
      ocnt_nxt = ocnt_r + OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ocnt_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  assign pix_in = in_ch.req_type ? '0 : {in_ch.in_red, in_ch.in_green, in_ch.in_blue};

  // line store: upper half is two lines up, lower half one line up
  rmd_ram #(.WIDTH(48), .DEPTH(MAX_WIDTH)) u_line_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col_r),
    .wdata ({one_up, s1_pix_r}),
    .re    (accept),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  assign s1_go       = s1_v_r && (!s1_primed_r || emit_ready);
  assign in_ch.ready = !s1_v_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  // bypass the line entry written at the same edge as this read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r      <= pix_in;
      s1_col_r      <= col_r;
      s1_ro_r       <= ro;
      s1_primed_r   <= primed;
      s1_eolmid_r   <= (WW'(col_r) == w_eff);
      s1_col0_r     <= (col_r == '0);
      s1_fwd_r      <= s1_go && (s1_col_r == col_r);
      s1_fwd_data_r <= {one_up, s1_pix_r};
    end
  end

  assign line    = s1_fwd_r ? s1_fwd_data_r : ram_rdata;
  assign two_up  = line[47:24];
  assign one_up  = line[23:0];
  assign ro_last = (s1_ro_r == h_eff - HW'(1));
  assign top     = (s1_ro_r == '0) ? one_up : two_up;
  assign bot     = ro_last ? one_up : s1_pix_r;

  // window: columns 0..2 left to right, rows 0..2 top to bottom
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_r[c][r] <= '0;
        end
      end
      win_row_r <= '0;
    end else if (s1_go) begin
      if (s1_col0_r) begin
        for (int c = 0; c < 3; c++) begin
          win_r[c][0] <= top;
          win_r[c][1] <= one_up;
          win_r[c][2] <= bot;
        end
      end else begin
        for (int r = 0; r < 3; r++) begin
          win_r[0][r] <= win_r[1][r];
          win_r[1][r] <= win_r[2][r];
        end
        win_r[2][0] <= top;
        win_r[2][1] <= one_up;
        win_r[2][2] <= bot;
      end
      win_row_r <= s1_ro_r;
    end
  end

  // line start closes the previous line: right edge repeated
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      taps[r]     = win_r[1][r];
      taps[3 + r] = win_r[2][r];
      taps[6 + r] = win_r[2][r];
    end
    if (!s1_col0_r) begin
      taps[6] = top;
      taps[7] = one_up;
      taps[8] = bot;
    end
  end

  assign emit_valid = s1_v_r && s1_primed_r;

  always_comb begin
    if (s1_col0_r) begin
      emit_tag.eol = 1'b1;
      emit_tag.eof = (win_row_r == h_eff - HW'(1));
    end else begin
      emit_tag.eol = s1_eolmid_r;
      emit_tag.eof = s1_eolmid_r && ro_last;
    end
  end

endmodule

/* design/rmd_lane.sv */
module rmd_lane (
  input  logic                                  clk,
  input  logic [rmd_pkg::BISECT_STEPS-1:0]      en,
  input  rmd_pkg::chan_t [rmd_pkg::WIN_TAPS-1:0] vals_in,
  output rmd_pkg::chan_t                        result
);

  localparam int STEPS = rmd_pkg::BISECT_STEPS;

  typedef struct packed {
    rmd_pkg::chan_t lo;
    rmd_pkg::chan_t hi;
  } bounds_t;

  function automatic bounds_t bisect_step(input rmd_pkg::chan_t [rmd_pkg::WIN_TAPS-1:0] v,
                                          input rmd_pkg::chan_t lo,
                                          input rmd_pkg::chan_t hi);
    logic [rmd_pkg::CHAN_W:0] sum;
    rmd_pkg::chan_t           mid;
    logic [3:0]               above;
    bounds_t                  nb;
    sum   = {1'b0, lo} + {1'b0, hi};
    mid   = sum[rmd_pkg::CHAN_W:1];
    above = '0;
    for (int j = 0; j < rmd_pkg::WIN_TAPS; j++) begin
      above = above + {3'b000, (v[j] > mid)};
    end
    nb.lo = lo;
    nb.hi = hi;
    if (above > 4'(rmd_pkg::MEDIAN_RANK)) begin
      nb.lo = mid;
    end else if (above < 4'(rmd_pkg::MEDIAN_RANK)) begin
      nb.hi = mid;
    end
    return nb;
  endfunction

  rmd_pkg::chan_t [rmd_pkg::WIN_TAPS-1:0] vals_r [STEPS-1];
  rmd_pkg::chan_t                         lo_r   [STEPS];
  rmd_pkg::chan_t                         hi_r   [STEPS];
  logic [rmd_pkg::CHAN_W:0]               fin_sum;

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    rmd_pkg::chan_t [rmd_pkg::WIN_TAPS-1:0] src_vals;
    rmd_pkg::chan_t                         src_lo;
    rmd_pkg::chan_t                         src_hi;
    bounds_t                                nb;

    if (k == 0) begin : g_first
      assign src_vals = vals_in;
      assign src_lo   = rmd_pkg::CHAN_MIN;
      assign src_hi   = rmd_pkg::CHAN_MAX;
    end else begin : g_next
      assign src_vals = vals_r[k-1];
      assign src_lo   = lo_r[k-1];
      assign src_hi   = hi_r[k-1];
    end

    assign nb = bisect_step(src_vals, src_lo, src_hi);

    always_ff @(posedge clk) begin
      if (en[k]) begin
        lo_r[k] <= nb.lo;
        hi_r[k] <= nb.hi;
      end
    end

    if (k < STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[k]) begin
          vals_r[k] <= src_vals;
        end
      end
    end
  end

  assign fin_sum = {1'b0, lo_r[STEPS-1]} + {1'b0, hi_r[STEPS-1]};
  assign result  = fin_sum[rmd_pkg::CHAN_W:1];

endmodule

/* design/rmd_merge.sv */
module rmd_merge (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           last_valid,
  input  rmd_pkg::tag_t  last_tag,
  input  rmd_pkg::chan_t red,
  input  rmd_pkg::chan_t green,
  input  rmd_pkg::chan_t blue,
  output logic           take,
  rmd_out_if.source      out_ch
);

  logic          out_v_r;
  rmd_pkg::pix_t out_pix_r;
  rmd_pkg::tag_t out_tag_r;

  // free when empty or when the held transaction leaves this cycle
  assign take = !out_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (take) begin
      out_v_r <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && last_valid) begin
      out_pix_r <= {red, green, blue};
      out_tag_r <= last_tag;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.out_red      = out_pix_r.red;
  assign out_ch.out_green    = out_pix_r.green;
  assign out_ch.out_blue     = out_pix_r.blue;
  assign out_ch.end_of_line  = out_tag_r.eol;
  assign out_ch.end_of_frame = out_tag_r.eof;

endmodule

/* design/rgb_median_denoise_3x3_unit.sv */
// 3x3 approximate median filter for an RGB24 raster stream, each colour on its own lane.
// in_ch carries one pixel per transaction (req_type 0) or a drain item (req_type 1),
// which counts as a black pixel. out_ch gives one filtered pixel per transaction with
// end_of_line / end_of_frame marks; image borders are clamped (edge pixels repeated).
// Output k leaves once k+W+1 input transactions have been taken (W = image width), so
// W+1 drain items flush the tail of the last frame.
// cfg_we/cfg_idx/cfg_wdata write image_width (index 0) and image_height (index 1);
// write them only while the block is empty.
// Throughput: one transaction per cycle on both sides while out_ch is ready. A result
// reaches out_ch after the transaction that releases it through the line store read,
// eight pipelined bisection stages per lane, then the output register.
// Both previous lines live in one line RAM (read at transaction, written when that transaction
// leaves the line store read register, with a bypass for back-to-back hits on one column).
// Reset (synchronous, rst_n low) clears counters, window and valid bits and restores
// width 640, height 480; the line RAM is not cleared and needs no clearing pass.
// When out_ch stalls, transactions keep being taken until the bisection pipeline is
// full, then in_ch.ready drops; nothing is lost or repeated.
module rgb_median_denoise_3x3_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rmd_in_if.sink                        in_ch,
  rmd_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [rmd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [rmd_pkg::DIM_W-1:0]     cfg_wdata
);

  localparam int STEPS = rmd_pkg::BISECT_STEPS;

  rmd_pkg::pix_t [rmd_pkg::WIN_TAPS-1:0]  taps;
  rmd_pkg::chan_t [rmd_pkg::WIN_TAPS-1:0] red_taps, green_taps, blue_taps;
  logic                                   emit_valid;
  rmd_pkg::tag_t                          emit_tag;

  logic [STEPS:0]   rdy;
  logic [STEPS-1:0] en;
  logic [STEPS-1:0] v_r;
  rmd_pkg::tag_t    tag_r [STEPS];
  logic             take;
  rmd_pkg::chan_t   red_med, green_med, blue_med;

  rmd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .emit_ready (rdy[0]),
    .emit_valid (emit_valid),
    .emit_tag   (emit_tag),
    .taps       (taps)
  );

  always_comb begin
    for (int j = 0; j < rmd_pkg::WIN_TAPS; j++) begin
      red_taps[j]   = taps[j].red;
      green_taps[j] = taps[j].green;
      blue_taps[j]  = taps[j].blue;
    end
  end

  // a stage takes new data when empty or when it hands on this cycle
  assign rdy[STEPS] = take;

  for (genvar k = 0; k < STEPS; k++) begin : g_ctrl
    logic up_valid;

    if (k == 0) begin : g_head
      assign up_valid = emit_valid;
    end else begin : g_body
      assign up_valid = v_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];
    assign en[k]  = rdy[k] && up_valid;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= up_valid;
      end
    end

    if (k == 0) begin : g_tag_head
      always_ff @(posedge clk) begin
        if (en[k]) begin
          tag_r[k] <= emit_tag;
        end
      end
    end else begin : g_tag_body
      always_ff @(posedge clk) begin
        if (en[k]) begin
          tag_r[k] <= tag_r[k-1];
        end
      end
    end
  end

  rmd_lane u_lane_red (
    .clk     (clk),
    .en      (en),
    .vals_in (red_taps),
    .result  (red_med)
  );

  rmd_lane u_lane_green (
    .clk     (clk),
    .en      (en),
    .vals_in (green_taps),
    .result  (green_med)
  );

  rmd_lane u_lane_blue (
    .clk     (clk),
    .en      (en),
    .vals_in (blue_taps),
    .result  (blue_med)
  );

  rmd_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .last_valid (v_r[STEPS-1]),
    .last_tag   (tag_r[STEPS-1]),
    .red        (red_med),
    .green      (green_med),
    .blue       (blue_med),
    .take       (take),
    .out_ch     (out_ch)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int MAX_W         = 2048;
  localparam int PRIME_W       = 40;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_LIMIT   = 4000;
  localparam int REPORT_LIMIT  = 200;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef logic [rmd_pkg::DIM_W-1:0] dim_t;

  typedef struct packed {
    rmd_pkg::pix_t pix;
    rmd_pkg::tag_t tag;
  } filt_res_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  rmd_pkg::cfg_reg_e cfg_idx;
  dim_t              cfg_wdata;

  rmd_in_if  in_ch ();
  rmd_out_if out_ch ();

  rgb_median_denoise_3x3_unit #(
    .MAX_WIDTH(MAX_W)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;
  int quiet_cycles  = 0;

  filt_res_t pending_filtered [$];
  string     field_name [5] = '{"out_red", "out_green", "out_blue", "end_of_line",
                                "end_of_frame"};

  // Filter state as the block should hold it
  rmd_pkg::pix_t upper_line [MAX_W] = '{default: '0};
  rmd_pkg::pix_t lower_line [MAX_W] = '{default: '0};
  rmd_pkg::pix_t win_taps [9]       = '{default: '0};  // column * 3 + row, row 0 on top
  int unsigned   col_pos  = 0;
  int unsigned   row_pos  = 0;
  int unsigned   fill_count = 0;
  int unsigned   win_line = 0;
  dim_t          width_reg  = rmd_pkg::WIDTH_RESET;
  dim_t          height_reg = rmd_pkg::HEIGHT_RESET;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bisection over one colour lane; lane 2 is red, 0 is blue
  function automatic rmd_pkg::chan_t bisect_median(input rmd_pkg::pix_t taps [9],
                                                   input int lane);
    rmd_pkg::chan_t lo;
    rmd_pkg::chan_t hi;
    rmd_pkg::chan_t mid;
    logic [8:0]     span;
    int             above;
    lo = rmd_pkg::CHAN_MIN;
    hi = rmd_pkg::CHAN_MAX;
    for (int s = 0; s < rmd_pkg::BISECT_STEPS; s++) begin
      span  = {1'b0, lo} + {1'b0, hi};
      mid   = span[8:1];
      above = 0;
      for (int j = 0; j < rmd_pkg::WIN_TAPS; j++) begin
        if (rmd_pkg::chan_t'(taps[j] >> (rmd_pkg::CHAN_W * lane)) > mid) above++;
      end
      if (above > rmd_pkg::MEDIAN_RANK) lo = mid;
      else if (above < rmd_pkg::MEDIAN_RANK) hi = mid;
    end
    span = {1'b0, lo} + {1'b0, hi};
    return span[8:1];
  endfunction

  function automatic filt_res_t window_median(input int cl, input int cm, input int cr,
                                              input logic eol, input logic eof);
    rmd_pkg::pix_t taps [9];
    filt_res_t     res;
    for (int r = 0; r < 3; r++) begin
      taps[r]     = win_taps[cl * 3 + r];
      taps[3 + r] = win_taps[cm * 3 + r];
      taps[6 + r] = win_taps[cr * 3 + r];
    end
    res.pix.red   = bisect_median(taps, 2);
    res.pix.green = bisect_median(taps, 1);
    res.pix.blue  = bisect_median(taps, 0);
    res.tag.eol   = eol;
    res.tag.eof   = eof;
    return res;
  endfunction

  // Advance the filter by one transaction; returns 1 when it releases a pixel
  function automatic bit filter_step(input logic req, input rmd_pkg::pix_t px,
                                     output filt_res_t res);
    int unsigned   w;
    int unsigned   h;
    int unsigned   ci;
    int unsigned   ri;
    int unsigned   ro;
    rmd_pkg::pix_t cur;
    rmd_pkg::pix_t two_up;
    rmd_pkg::pix_t one_up;
    rmd_pkg::pix_t top;
    rmd_pkg::pix_t bot;
    bit            primed;
    logic          eol;
    w = width_reg;
    h = height_reg;
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    if (h == 0) h = 1;
    cur = (req == REQ_DRAIN) ? rmd_pkg::pix_t'(0) : px;
    ci  = col_pos;
    if (ci >= MAX_W) ci = 0;
    ri  = row_pos;
    res = '0;

    two_up         = upper_line[ci];
    one_up         = lower_line[ci];
    upper_line[ci] = one_up;
    lower_line[ci] = cur;

    // clamp vertically on the row this column of the window belongs to
    ro  = (ri == 0) ? h - 1 : ri - 1;
    top = (ro == 0) ? one_up : two_up;
    bot = (ro == h - 1) ? one_up : cur;
    primed = fill_count >= w + 1;

    if (ci == 0) begin
      if (primed) res = window_median(1, 2, 2, 1'b1, win_line == h - 1);
      for (int c = 0; c < 3; c++) begin
        win_taps[c * 3]     = top;
        win_taps[c * 3 + 1] = one_up;
        win_taps[c * 3 + 2] = bot;
      end
    end else begin
      for (int j = 0; j < 6; j++) win_taps[j] = win_taps[j + 3];
      win_taps[6] = top;
      win_taps[7] = one_up;
      win_taps[8] = bot;
      if (primed) begin
        eol = (ci == w);
        res = window_median(0, 1, 2, eol, eol && ro == h - 1);
      end
    end
    win_line = ro;
    if (!primed) fill_count++;

    ci++;
    if (ci >= w) begin
      ci = 0;
      ri++;
      if (ri >= h) ri = 0;
    end
    col_pos = ci;
    row_pos = ri;
    return primed;
  endfunction

  function automatic int eff_width(input dim_t w);
    if (w == 0) return 1;
    if (w > MAX_W) return MAX_W;
    return w;
  endfunction

  // Mix of full-range values, extremes and a cluster round base to provoke ties
  function automatic rmd_pkg::chan_t rand_chan(input rmd_pkg::chan_t base);
    rmd_pkg::chan_t v;
    case ($urandom_range(3))
      0, 1: v = rmd_pkg::chan_t'($urandom_range(255));
      2: begin
        case ($urandom_range(3))
          0:       v = rmd_pkg::CHAN_MIN;
          1:       v = rmd_pkg::CHAN_MAX;
          2:       v = 8'h7f;
          default: v = 8'h80;
        endcase
      end
      default: v = rmd_pkg::chan_t'(base + $urandom_range(6) - 3);
    endcase
    return v;
  endfunction

  function automatic rmd_pkg::pix_t rand_pixel(input rmd_pkg::chan_t base);
    rmd_pkg::pix_t px;
    px.red   = rand_chan(base);
    px.green = rand_chan(base);
    px.blue  = rand_chan(base);
    return px;
  endfunction

  function automatic rmd_pkg::chan_t rand_base();
    return rmd_pkg::chan_t'($urandom_range(255));
  endfunction

  task automatic send_item(input logic req, input rmd_pkg::pix_t px);
    filt_res_t res;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.in_red   <= px.red;
    in_ch.in_green <= px.green;
    in_ch.in_blue  <= px.blue;
    do @(posedge clk); while (!in_ch.ready);
    if (filter_step(req, px, res)) pending_filtered.push_back(res);
  endtask

  // Drain items carry junk pixel data, which must be ignored
  task automatic send_drains(input int n);
    repeat (n) send_item(REQ_DRAIN, rand_pixel(rand_base()));
  endtask

  task automatic wait_results_out();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input rmd_pkg::cfg_reg_e idx, input dim_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      rmd_pkg::CFG_IMAGE_WIDTH:  width_reg  = val;
      rmd_pkg::CFG_IMAGE_HEIGHT: height_reg = val;
      default: ;
    endcase
  endtask

  // Reconfigure only once the block is empty
  task automatic configure(input dim_t w, input dim_t h);
    wait_results_out();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(rmd_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(rmd_pkg::CFG_IMAGE_HEIGHT, h);
  endtask

  // Two lines at the widest width used later write every line store entry
  // that a later frame can read
  task automatic test_line_priming();
    rmd_pkg::chan_t base;
    base = rand_base();
    configure(dim_t'(PRIME_W), 12'd2);
    repeat (2 * PRIME_W) send_item(REQ_PIXEL, rand_pixel(base));
    send_drains(PRIME_W + 1);
  endtask

  task automatic test_tie_patterns();
    rmd_pkg::pix_t pat [9];
    pat = '{24'h00ff80, 24'hff007f, 24'h807f00,
            24'h7f80ff, 24'h000000, 24'hffffff,
            24'h01fe40, 24'hc03f80, 24'h808080};
    configure(12'd3, 12'd3);
    for (int i = 0; i < 9; i++) send_item(REQ_PIXEL, pat[i]);
    send_drains(4);
  endtask

  // Zero sizes act as one; widths of one and two still clamp correctly
  task automatic test_narrow_frames();
    dim_t dims [3][2];
    int   px_cnt [3];
    dims   = '{'{12'd0, 12'd0}, '{12'd1, 12'd4095}, '{12'd2, 12'd2}};
    px_cnt = '{2, 2, 4};
    for (int k = 0; k < 3; k++) begin
      configure(dims[k][0], dims[k][1]);
      repeat (px_cnt[k]) send_item(REQ_PIXEL, rand_pixel(rand_base()));
      send_drains(eff_width(dims[k][0]) + 1);
    end
  endtask

  // Shrink both sizes while the position lies beyond them
  task automatic test_resize_mid_frame();
    configure(12'd4, 12'd3);
    repeat (10) send_item(REQ_PIXEL, rand_pixel(rmd_pkg::CHAN_MAX));
    configure(12'd2, 12'd2);
    repeat (2) send_item(REQ_PIXEL, rand_pixel(rmd_pkg::CHAN_MIN));
    send_drains(3);
  endtask

  task automatic test_random_frames(input int n_items);
    int             sent;
    int             w_eff;
    int             h_eff;
    int             rows;
    int             n_px;
    int             pause_at;
    int             n_flush;
    int             pick;
    dim_t           w;
    dim_t           h;
    rmd_pkg::chan_t base;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 6) w = dim_t'($urandom_range(2));
      else if (pick < 94) w = dim_t'($urandom_range(3, 12));
      else w = dim_t'($urandom_range(13, PRIME_W));
      pick = $urandom_range(99);
      if (pick < 5) h = '0;
      else if (pick < 8) h = 12'd4095;
      else h = dim_t'($urandom_range(1, 6));
      configure(w, h);
      w_eff = eff_width(w);
      h_eff = (h == 0) ? 1 : h;
      rows  = (h_eff > 8) ? 3 : h_eff;
      base  = rand_base();
      repeat ($urandom_range(1, 3)) begin
        base     = rand_base();
        n_px     = w_eff * rows;
        pause_at = ($urandom_range(29) == 0) ? $urandom_range(n_px - 1) : -1;
        for (int i = 0; i < n_px; i++) begin
          // hold the stream now and then until everything owed has come out
          if (i == pause_at) wait_results_out();
          if ($urandom_range(99) < 3) send_item(REQ_DRAIN, rand_pixel(base));
          else send_item(REQ_PIXEL, rand_pixel(base));
        end
        sent += n_px;
      end
      n_flush = ($urandom_range(4) == 0) ? $urandom_range(w_eff) : w_eff + 1;
      send_drains(n_flush);
      sent += n_flush;
    end
  endtask

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    filt_res_t  want;
    logic [7:0] got_f [5];
    logic [7:0] want_f [5];
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_filtered.size() == 0) begin
        if (error_count < REPORT_LIMIT)
          $error("filtered pixel %h/%h/%h with none outstanding",
                 out_ch.out_red, out_ch.out_green, out_ch.out_blue);
        error_count++;
      end else begin
        want   = pending_filtered.pop_front();
        got_f  = '{out_ch.out_red, out_ch.out_green, out_ch.out_blue,
                   8'(out_ch.end_of_line), 8'(out_ch.end_of_frame)};
        want_f = '{want.pix.red, want.pix.green, want.pix.blue,
                   8'(want.tag.eol), 8'(want.tag.eof)};
        for (int i = 0; i < 5; i++) begin
          if (got_f[i] !== want_f[i]) begin
            if (error_count < REPORT_LIMIT)
              $error("%s mismatch: expected %0d, got %0d", field_name[i], want_f[i], got_f[i]);
            error_count++;
          end
        end
      end
    end
  end

  // Stop if neither side moves a transaction for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = rmd_pkg::CFG_IMAGE_WIDTH;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_PIXEL;
    in_ch.in_red   = '0;
    in_ch.in_green = '0;
    in_ch.in_blue  = '0;
    out_ch.ready   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 21;
    recv_idle_pct = 77;
    test_line_priming();
    test_tie_patterns();
    test_narrow_frames();
    test_resize_mid_frame();
    test_random_frames(RANDOM_ITEMS / 3);

    send_idle_pct = 77;
    recv_idle_pct = 21;
    test_random_frames(RANDOM_ITEMS / 3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    wait_results_out();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
